// ===== design/lps_pkg.sv =====
// shared types, constants and step functions for the led pattern sequencer
package lps_pkg;

	localparam int unsigned LED_W   = 8;
	localparam int unsigned MODE_W  = 3;
	localparam int unsigned STEP_W  = 4;
	localparam int unsigned TICK_W  = 16;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [TICK_W-1:0] FLASH_TICKS_RST = 16'd500;
	localparam logic [TICK_W-1:0] SHIFT_TICKS_RST = 16'd250;
	localparam logic [TICK_W-1:0] PAIR_TICKS_RST  = 16'd300;

	typedef enum logic [MODE_W-1:0] {
		MODE_TOGGLE   = 3'd0,
		MODE_UP       = 3'd1,
		MODE_DOWN     = 3'd2,
		MODE_CONVERGE = 3'd3,
		MODE_DIVERGE  = 3'd4,
		MODE_PINGPONG = 3'd5,
		MODE_SNAKE    = 3'd6,
		MODE_CONV_DIV = 3'd7
	} lps_mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FLASH_TICKS = 2'd0,
		REG_SHIFT_TICKS = 2'd1,
		REG_PAIR_TICKS  = 2'd2,
		REG_UNUSED      = 2'd3
	} lps_reg_t;

	typedef struct packed {
		logic [TICK_W-1:0] flash_ticks;
		logic [TICK_W-1:0] shift_ticks;
		logic [TICK_W-1:0] pair_ticks;
	} lps_cfg_t;

	typedef struct packed {
		logic [LED_W-1:0]  led_levels;
		lps_mode_t         active_mode;
		logic [STEP_W-1:0] step_index;
		logic [TICK_W-1:0] tick_count;
	} lps_state_t;

	function automatic logic [LED_W-1:0] bit_of(input logic [2:0] n);
		return LED_W'(1) << n;
	endfunction

	function automatic logic [LED_W-1:0] pair_mask(input logic [1:0] i);
		return bit_of({1'b0, i}) | bit_of(3'd7 - {1'b0, i});
	endfunction

	function automatic logic [STEP_W-1:0] steps_in_run(input lps_mode_t mode);
		logic [STEP_W-1:0] n;
		unique case (mode)
			MODE_TOGGLE:                 n = 4'd1;
			MODE_CONVERGE, MODE_DIVERGE: n = 4'd4;
			MODE_PINGPONG:               n = 4'd15;
			default:                     n = 4'd8;
		endcase
		return n;
	endfunction

	function automatic logic [LED_W-1:0] step_mask(input lps_mode_t mode,
			input logic [STEP_W-1:0] s);
		logic [LED_W-1:0] m;
		unique case (mode)
			MODE_UP, MODE_SNAKE: m = bit_of(s[2:0]);
			MODE_DOWN:           m = bit_of(3'd7 - s[2:0]);
			MODE_CONVERGE:       m = pair_mask(s[1:0]);
			MODE_DIVERGE:        m = pair_mask(2'd3 - s[1:0]);
			MODE_PINGPONG:       m = s[3] ? bit_of(3'(4'd14 - s)) : bit_of(s[2:0]);
			MODE_CONV_DIV:       m = s[3:2] == 2'd0 ? pair_mask(s[1:0])
			                                        : pair_mask(2'd3 - s[1:0]);
			default:             m = '1;
		endcase
		return m;
	endfunction

endpackage

// ===== design/led_pattern_sequencer.sv =====
// top level of the led pattern sequencer: input stage, state and result register
// Each input transaction is one 1 ms tick carrying the three switch bits; each tick
// returns exactly one output transaction with the eight LED levels held during it.
// The switches only matter on the first tick of a pattern run, after which the run
// plays to its end. A tick is captured in an input register, the step logic works
// on it and the LED levels land in a result register, where they are held until
// the output side takes them. One tick can be accepted every cycle while the output
// side keeps taking results. The figure is set by the single state update per tick
// (counter compare and bit updates). The three period registers reset to 500, 250
// and 300 ticks and are written through the configuration channel, which is always
// ready; writes to index 3 are dropped.
module led_pattern_sequencer (
	input  logic                             clk,
	input  logic                             arst_n,
	// tick channel
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [lps_pkg::MODE_W-1:0]       switches,
	// led channel
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [lps_pkg::LED_W-1:0]        leds,
	// configuration channel
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [lps_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lps_pkg::TICK_W-1:0]       cfg_data
);
	import lps_pkg::*;

	lps_cfg_t          cfg;
	lps_state_t        state_q;
	lps_state_t        state_nxt;
	logic [LED_W-1:0]  leds_nxt;
	logic [LED_W-1:0]  leds_q;
	logic              out_valid_q;
	logic              valid_s1;
	logic [MODE_W-1:0] switches_s1;
	logic              in_take;
	logic              advance;

	lps_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lps_step_logic u_step (
		.cfg      (cfg),
		.cur      (state_q),
		.switches (switches_s1),
		.nxt      (state_nxt),
		.leds     (leds_nxt)
	);

	// the captured tick moves on when the result register is free or being emptied
	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign in_take   = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign leds      = leds_q;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			switches_s1 <= switches;
		end
	end

	// sequencer state, updated once per tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.led_levels  <= '0;
			state_q.active_mode <= MODE_TOGGLE;
			state_q.step_index  <= '0;
			state_q.tick_count  <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			leds_q <= leds_nxt;
		end
	end

endmodule

// ===== design/lps_cfg_regs.sv =====
// period registers written through the configuration channel
module lps_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [lps_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lps_pkg::TICK_W-1:0]       cfg_data,
	output lps_pkg::lps_cfg_t                cfg
);
	import lps_pkg::*;

	lps_cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.flash_ticks <= FLASH_TICKS_RST;
			cfg_q.shift_ticks <= SHIFT_TICKS_RST;
			cfg_q.pair_ticks  <= PAIR_TICKS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (lps_reg_t'(cfg_index))
				REG_FLASH_TICKS: cfg_q.flash_ticks <= cfg_data;
				REG_SHIFT_TICKS: cfg_q.shift_ticks <= cfg_data;
				REG_PAIR_TICKS:  cfg_q.pair_ticks  <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// ===== design/lps_step_logic.sv =====
// one tick of the sequencer: led output and next state
module lps_step_logic (
	input  lps_pkg::lps_cfg_t              cfg,
	input  lps_pkg::lps_state_t            cur,
	input  logic [lps_pkg::MODE_W-1:0]     switches,
	output lps_pkg::lps_state_t            nxt,
	output logic [lps_pkg::LED_W-1:0]      leds
);
	import lps_pkg::*;

	logic              run_start;
	lps_mode_t         mode;
	logic [LED_W-1:0]  mask;
	logic [LED_W-1:0]  lit;
	logic [TICK_W-1:0] period_raw;
	logic [TICK_W-1:0] period;
	logic              step_done;
	logic [STEP_W-1:0] step_inc;

	always_comb begin
		run_start = (cur.step_index == '0) && (cur.tick_count == '0);
		mode      = run_start ? lps_mode_t'(switches) : cur.active_mode;
		mask      = step_mask(mode, cur.step_index);

		if (cur.tick_count == '0)
			lit = (mode == MODE_TOGGLE) ? ~cur.led_levels : (cur.led_levels | mask);
		else
			lit = cur.led_levels;

		unique case (mode)
			MODE_TOGGLE:                                period_raw = cfg.flash_ticks;
			MODE_CONVERGE, MODE_DIVERGE, MODE_CONV_DIV: period_raw = cfg.pair_ticks;
			default:                                    period_raw = cfg.shift_ticks;
		endcase
		// a zero period behaves as one tick
		period = (period_raw == '0) ? TICK_W'(1) : period_raw;

		step_done = ({1'b0, cur.tick_count} + (TICK_W+1)'(1)) >= {1'b0, period};
		step_inc  = cur.step_index + STEP_W'(1);

		leds            = lit;
		nxt.active_mode = mode;
		nxt.led_levels  = lit;
		nxt.step_index  = cur.step_index;
		nxt.tick_count  = cur.tick_count + TICK_W'(1);

		if (step_done) begin
			if (mode != MODE_TOGGLE && mode != MODE_SNAKE)
				nxt.led_levels = lit & ~mask;
			nxt.tick_count = '0;
			nxt.step_index = step_inc;
			if (step_inc >= steps_in_run(mode)) begin
				nxt.step_index = '0;
				if (mode == MODE_UP || mode == MODE_DOWN || mode == MODE_SNAKE)
					nxt.led_levels = '0;
			end
		end
	end

endmodule

// ===== test/tb_led_pattern_sequencer.sv =====
// self-checking testbench for the led pattern sequencer with its own tick-level predictor
module tb_led_pattern_sequencer;
	timeunit 1ns;
	timeprecision 1ps;

	import lps_pkg::*;

	// idle cycles after the last owed transaction has come out, before registers are touched
	localparam int DRAIN_CYCLES  = 4;
	// cycles with no transaction at all before the run is declared hung
	localparam int HANG_LIMIT    = 2000;
	localparam int RANDOM_TICKS  = 600;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [MODE_W-1:0]    switches;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [LED_W-1:0]     leds;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [TICK_W-1:0]    cfg_data;

	led_pattern_sequencer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.switches  (switches),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.leds      (leds),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 100 MHz clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// ---------------------------------------------------------------
	// predictor: shadow copy of the period registers and sequencer state
	// ---------------------------------------------------------------
	logic [TICK_W-1:0] flash_period, shift_period, pair_period;
	logic [LED_W-1:0]  shadow_leds;
	lps_mode_t         shadow_mode;
	logic [STEP_W-1:0] shadow_step;
	logic [TICK_W-1:0] shadow_tick;

	// led levels still owed by the block, oldest first
	logic [LED_W-1:0] leds_due_q[$];

	int  mismatches  = 0;
	int  ticks_sent  = 0;
	bit  in_idle_on  = 1'b0;
	bit  out_idle_on = 1'b0;

	function automatic logic [LED_W-1:0] one_led(input int n);
		return LED_W'(1) << (n & 7);
	endfunction

	// led n together with its mirror image across the middle of the bar
	function automatic logic [LED_W-1:0] mirrored(input int n);
		return one_led(n) | one_led(7 - n);
	endfunction

	function automatic logic [LED_W-1:0] lit_for_step(input lps_mode_t m, input int s);
		case (m)
			MODE_UP, MODE_SNAKE: return one_led(s);
			MODE_DOWN:           return one_led(7 - s);
			MODE_CONVERGE:       return mirrored(s & 3);
			MODE_DIVERGE:        return mirrored(3 - (s & 3));
			MODE_PINGPONG:       return (s < 8) ? one_led(s) : one_led(14 - s);
			MODE_CONV_DIV:       return (s < 4) ? mirrored(s) : mirrored(3 - ((s - 4) & 3));
			default:             return '1;
		endcase
	endfunction

	function automatic int run_length(input lps_mode_t m);
		case (m)
			MODE_TOGGLE:                 return 1;
			MODE_CONVERGE, MODE_DIVERGE: return 4;
			MODE_PINGPONG:               return 15;
			default:                     return 8;
		endcase
	endfunction

	// a register holding zero behaves as a one-tick period
	function automatic int step_period(input lps_mode_t m);
		logic [TICK_W-1:0] p;
		case (m)
			MODE_TOGGLE:                                p = flash_period;
			MODE_CONVERGE, MODE_DIVERGE, MODE_CONV_DIV: p = pair_period;
			default:                                    p = shift_period;
		endcase
		return (p == '0) ? 1 : int'(p);
	endfunction

	// advance the shadow state by one tick and return the levels shown during it
	function automatic logic [LED_W-1:0] predict_tick(input logic [MODE_W-1:0] sw);
		logic [LED_W-1:0] lit;
		logic [LED_W-1:0] shown;
		// switches only count on the first tick of a run
		if (shadow_step == '0 && shadow_tick == '0)
			shadow_mode = lps_mode_t'(sw);
		lit = lit_for_step(shadow_mode, int'(shadow_step));
		if (shadow_tick == '0) begin
			if (shadow_mode == MODE_TOGGLE)
				shadow_leds = ~shadow_leds;
			else
				shadow_leds = shadow_leds | lit;
		end
		shown = shadow_leds;
		if (int'(shadow_tick) + 1 >= step_period(shadow_mode)) begin
			// snake keeps its bits, toggle has none of its own to clear
			if (shadow_mode != MODE_TOGGLE && shadow_mode != MODE_SNAKE)
				shadow_leds = shadow_leds & ~lit;
			shadow_tick = '0;
			shadow_step = shadow_step + 1'b1;
			if (int'(shadow_step) >= run_length(shadow_mode)) begin
				shadow_step = '0;
				if (shadow_mode inside {MODE_UP, MODE_DOWN, MODE_SNAKE})
					shadow_leds = '0;
			end
		end else begin
			shadow_tick = shadow_tick + 1'b1;
		end
		return shown;
	endfunction

	// ---------------------------------------------------------------
	// tick channel driver
	// ---------------------------------------------------------------
	// valid is only lowered when a gap is drawn, so back-to-back ticks keep it high
	task automatic send_tick(input logic [MODE_W-1:0] sw);
		int gap;
		gap = in_idle_on ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		switches <= sw;
		do @(posedge clk); while (in_stall);
		leds_due_q.push_back(predict_tick(sw));
		ticks_sent++;
	endtask

	// first tick carries the mode, the rest of the run carries noise on the switches
	task automatic play_run(input lps_mode_t m, input int n_ticks);
		send_tick(m);
		for (int i = 1; i < n_ticks; i++)
			send_tick(MODE_W'($urandom_range(0, 7)));
	endtask

	// stop ticking and let every owed transaction come out before touching registers
	task automatic drain();
		in_valid <= 1'b0;
		while (leds_due_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// ---------------------------------------------------------------
	// configuration channel driver, only used while the block is drained
	// ---------------------------------------------------------------
	task automatic write_reg(input lps_reg_t idx, input logic [TICK_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_FLASH_TICKS: flash_period = val;
			REG_SHIFT_TICKS: shift_period = val;
			REG_PAIR_TICKS:  pair_period  = val;
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// mostly short periods so runs finish, now and then the edges of the range
	function automatic logic [TICK_W-1:0] pick_period();
		int r;
		r = $urandom_range(0, 19);
		case (r)
			0:       return '0;
			1:       return '1;
			2:       return TICK_W'($urandom);
			default: return TICK_W'($urandom_range(1, 6));
		endcase
	endfunction

	// ---------------------------------------------------------------
	// led channel monitor and stall generator
	// ---------------------------------------------------------------
	int stall_left = 0;

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (leds_due_q.size() == 0) begin
				$display("%t unexpected led transaction: expected none, actual %h",
					$time, leds);
				mismatches++;
			end else begin
				logic [LED_W-1:0] due;
				due = leds_due_q.pop_front();
				if (leds !== due) begin
					$display("%t leds mismatch: expected %h, actual %h", $time, due, leds);
					mismatches++;
				end
			end
			stall_left = out_idle_on ? $urandom_range(0, 19) : 0;
		end
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// hang detection: any transaction on any channel restarts the count
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
					(cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= HANG_LIMIT) begin
				$display("%t no transaction for %0d cycles", $time, HANG_LIMIT);
				$display("[led_pattern_sequencer] ERROR");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------
	// reset periods are in force: first tick of a toggle run lights everything
	task automatic test_reset_values();
		play_run(MODE_TOGGLE, 3);
		drain();
	endtask

	// a write to the spare index must leave all three periods alone
	task automatic test_spare_index();
		write_reg(REG_UNUSED, 16'hFFFF);
		write_reg(REG_UNUSED, 16'h0000);
		send_tick(MODE_W'(MODE_TOGGLE));
		drain();
	endtask

	// one-tick periods; the pending toggle step is cut short by the smaller period
	task automatic test_pair_modes();
		write_reg(REG_FLASH_TICKS, 16'd1);
		write_reg(REG_SHIFT_TICKS, 16'd1);
		write_reg(REG_PAIR_TICKS, 16'd1);
		send_tick(MODE_W'(MODE_TOGGLE));
		play_run(MODE_CONVERGE, 4);
		play_run(MODE_CONV_DIV, 8);
		drain();
	endtask

	// a zero shift period must step every tick, snake fill then clears at the end
	task automatic test_zero_period();
		write_reg(REG_SHIFT_TICKS, 16'd0);
		play_run(MODE_SNAKE, 8);
		drain();
	endtask

	// phases of random periods and random switch traffic with random idling
	task automatic test_random_phases();
		int phase_len;
		int goal;
		goal = ticks_sent + RANDOM_TICKS;
		while (ticks_sent < goal) begin
			write_reg(REG_FLASH_TICKS, pick_period());
			write_reg(REG_SHIFT_TICKS, pick_period());
			write_reg(REG_PAIR_TICKS, pick_period());
			if ($urandom_range(0, 5) == 0)
				write_reg(REG_UNUSED, TICK_W'($urandom));
			in_idle_on  = ($urandom_range(0, 2) != 0);
			out_idle_on = ($urandom_range(0, 2) != 0);
			phase_len = $urandom_range(10, 50);
			for (int i = 0; i < phase_len; i++)
				send_tick(MODE_W'($urandom_range(0, 7)));
			drain();
		end
		// leave the period registers at their top value for one last short phase
		write_reg(REG_FLASH_TICKS, '1);
		write_reg(REG_SHIFT_TICKS, '1);
		write_reg(REG_PAIR_TICKS, '1);
		for (int i = 0; i < 10; i++)
			send_tick(MODE_W'($urandom_range(0, 7)));
		drain();
	endtask

	// ---------------------------------------------------------------
	// main sequence
	// ---------------------------------------------------------------
	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		switches  = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_FLASH_TICKS;
		cfg_data  = '0;

		flash_period = FLASH_TICKS_RST;
		shift_period = SHIFT_TICKS_RST;
		pair_period  = PAIR_TICKS_RST;
		shadow_leds  = '0;
		shadow_mode  = MODE_TOGGLE;
		shadow_step  = '0;
		shadow_tick  = '0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_spare_index();
		test_pair_modes();
		test_zero_period();
		test_random_phases();

		repeat (10) @(posedge clk);
		if (mismatches == 0 && leds_due_q.size() == 0) begin
			$display("[led_pattern_sequencer] OK");
		end else begin
			$display("[led_pattern_sequencer] ERROR");
		end
		$finish;
	end

endmodule
